// ----- rtl/mlfq_pkg.sv -----
// Shared constants, codes, state encoding and control structs for the MLFQ
// priority update engine. No dependencies.
`timescale 1ns / 1ps

package mlfq_pkg;

    // Table geometry and fixed-point format
    localparam int THREAD_SLOTS  = 64;
    localparam int SLOT_W        = $clog2(THREAD_SLOTS);
    localparam int PRIORITY_MAX  = 63;
    localparam int PRI_W         = $clog2(PRIORITY_MAX + 1);
    localparam int FRACTION_BITS = 14;
    localparam int FP_ONE        = 1 << FRACTION_BITS;
    localparam int FP_HALF       = FP_ONE / 2;

    // Port field widths
    localparam int OP_W         = 3;
    localparam int SLOT_FIELD_W = 6;
    localparam int NICE_IN_W    = 8;
    localparam int READY_W      = 7;
    localparam int LA_OUT_W     = 20;
    localparam int RC_OUT_W     = 25;
    localparam int PRIO_OUT_W   = 6;

    // Internal widths
    localparam int NICE_W  = 6;
    localparam int RCPU_W  = 32;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = 48;
    localparam int RAM_W   = NICE_W + RCPU_W + PRI_W;

    // Arithmetic constants
    localparam int C59        = (59 * FP_ONE) / 60;
    localparam int C1         = FP_ONE / 60;
    localparam int NICE_LIMIT = 20;
    localparam int PCT_SCALE  = 100;
    localparam int LA_OUT_MAX = 1000000;
    localparam int RC_OUT_MAX = 13107100;
    localparam int RC_OUT_MIN = -13107200;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 3'd0,
        OP_RECALC   = 3'd1,
        OP_SET_NICE = 3'd2,
        OP_CREATE   = 3'd3,
        OP_EXIT     = 3'd4,
        OP_QUERY    = 3'd5
    } opcode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_T_RD,
        ST_T_LATCH,
        ST_T_ADD,
        ST_L_MUL,
        ST_L_UPD,
        ST_DIV_INIT,
        ST_DIV,
        ST_W_CHECK,
        ST_U_RD,
        ST_U_LATCH,
        ST_U_MUL,
        ST_U_RCPU,
        ST_C_RD,
        ST_C_LATCH,
        ST_PRIO,
        ST_WR,
        ST_EXIT,
        ST_RP_RD,
        ST_RP_LATCH,
        ST_RP_MLA,
        ST_RP_LA,
        ST_RP_MRC,
        ST_RP_RC,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic mul_load59;
        logic load_upd;
        logic idx_clr;
        logic idx_inc;
        logic div_init;
        logic div_step;
        logic rd_parent;
        logic rd_report;
        logic latch;
        logic use_nice_in;
        logic mul_coeff;
        logic rcpu_upd;
        logic tick_add;
        logic prio_upd;
        logic wr;
        logic live_set;
        logic live_clr;
        logic mul_la;
        logic la_out;
        logic mul_rc;
        logic rc_out;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            in_valid;
        logic            is_idle;
        logic            walk_ok;
        logic            idx_last;
        logic            div_done;
        logic            out_free;
    } ctrl_sts_t;

endpackage

// ----- rtl/mlfq_in_if.sv -----
// Event channel: valid/ready handshake with the event fields.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

interface mlfq_in_if;
    import mlfq_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           opcode;
    logic [SLOT_FIELD_W-1:0]   thread_slot;
    logic [SLOT_FIELD_W-1:0]   parent_slot;
    logic signed [NICE_IN_W-1:0] nice_value;
    logic [READY_W-1:0]        ready_list_length;

    modport source (output valid, opcode, thread_slot, parent_slot, nice_value,
                    ready_list_length, input ready);
    modport sink   (input valid, opcode, thread_slot, parent_slot, nice_value,
                    ready_list_length, output ready);
endinterface

// ----- rtl/mlfq_out_if.sv -----
// Result channel: valid/ready handshake with the report fields.
// Depends on mlfq_pkg.
`timescale 1ns / 1ps

interface mlfq_out_if;
    import mlfq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [LA_OUT_W-1:0]        load_avg_x100;
    logic signed [RC_OUT_W-1:0] recent_cpu_x100;
    logic [PRIO_OUT_W-1:0]      thread_priority;

    modport source (output valid, load_avg_x100, recent_cpu_x100, thread_priority,
                    input ready);
    modport sink   (input valid, load_avg_x100, recent_cpu_x100, thread_priority,
                    output ready);
endinterface

// ----- rtl/mlfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/mlfq_ctrl.sv -----
// Sequencing state machine: walks each event through read, compute, write and
// report steps. Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  mlfq_pkg::ctrl_sts_t sts,
    output mlfq_pkg::ctrl_cmd_t cmd
);
    import mlfq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.op)
                    OP_TICK:     state_next = sts.is_idle ? ST_RP_RD : ST_T_RD;
                    OP_RECALC:   state_next = ST_L_MUL;
                    OP_SET_NICE: state_next = sts.is_idle ? ST_RP_RD : ST_DIV_INIT;
                    OP_CREATE:   state_next = sts.is_idle ? ST_RP_RD : ST_C_RD;
                    OP_EXIT:     state_next = sts.is_idle ? ST_RP_RD : ST_EXIT;
                    default:     state_next = ST_RP_RD;
                endcase
            end
            ST_T_RD:     state_next = ST_T_LATCH;
            ST_T_LATCH:  state_next = ST_T_ADD;
            ST_T_ADD:    state_next = ST_WR;
            ST_L_MUL:    state_next = ST_L_UPD;
            ST_L_UPD:    state_next = ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = (sts.op == OP_RECALC) ? ST_W_CHECK : ST_U_RD;
                end
            end
            ST_W_CHECK:
            begin
                if (sts.walk_ok)
                begin
                    state_next = ST_U_RD;
                end
                else if (sts.idx_last)
                begin
                    state_next = ST_RP_RD;
                end
            end
            ST_U_RD:     state_next = ST_U_LATCH;
            ST_U_LATCH:  state_next = ST_U_MUL;
            ST_U_MUL:    state_next = ST_U_RCPU;
            ST_U_RCPU:   state_next = ST_PRIO;
            ST_C_RD:     state_next = ST_C_LATCH;
            ST_C_LATCH:  state_next = ST_PRIO;
            ST_PRIO:     state_next = ST_WR;
            ST_WR:
            begin
                if (sts.op == OP_RECALC && !sts.idx_last)
                begin
                    state_next = ST_W_CHECK;
                end
                else
                begin
                    state_next = ST_RP_RD;
                end
            end
            ST_EXIT:     state_next = ST_RP_RD;
            ST_RP_RD:    state_next = ST_RP_LATCH;
            ST_RP_LATCH: state_next = ST_RP_MLA;
            ST_RP_MLA:   state_next = ST_RP_LA;
            ST_RP_LA:    state_next = ST_RP_MRC;
            ST_RP_MRC:   state_next = ST_RP_RC;
            ST_RP_RC:    state_next = ST_FIN;
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:     cmd.in_ready = 1'b1;
            ST_T_LATCH:  cmd.latch = 1'b1;
            ST_T_ADD:    cmd.tick_add = 1'b1;
            ST_L_MUL:
            begin
                cmd.mul_load59 = 1'b1;
                cmd.idx_clr    = 1'b1;
            end
            ST_L_UPD:    cmd.load_upd = 1'b1;
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV:      cmd.div_step = !sts.div_done;
            ST_W_CHECK:  cmd.idx_inc = !sts.walk_ok && !sts.idx_last;
            ST_U_LATCH:
            begin
                cmd.latch       = 1'b1;
                cmd.use_nice_in = (sts.op == OP_SET_NICE);
            end
            ST_U_MUL:    cmd.mul_coeff = 1'b1;
            ST_U_RCPU:   cmd.rcpu_upd = 1'b1;
            ST_C_RD:     cmd.rd_parent = 1'b1;
            ST_C_LATCH:  cmd.latch = 1'b1;
            ST_PRIO:     cmd.prio_upd = 1'b1;
            ST_WR:
            begin
                cmd.wr       = 1'b1;
                cmd.live_set = (sts.op == OP_CREATE);
                cmd.idx_inc  = (sts.op == OP_RECALC) && !sts.idx_last;
            end
            ST_EXIT:     cmd.live_clr = 1'b1;
            ST_RP_RD:    cmd.rd_report = 1'b1;
            ST_RP_LATCH: cmd.latch = 1'b1;
            ST_RP_MLA:   cmd.mul_la = 1'b1;
            ST_RP_LA:    cmd.la_out = 1'b1;
            ST_RP_MRC:   cmd.mul_rc = 1'b1;
            ST_RP_RC:    cmd.rc_out = 1'b1;
            ST_FIN:      cmd.out_load = sts.out_free;
            default:     cmd = '0;
        endcase
    end
endmodule

// ----- rtl/mlfq_dpath.sv -----
// Datapath: thread table RAM, live/valid bits, load average, shared multiplier,
// restoring divider for the decay coefficient, and the result register.
// Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if and mlfq_ram.
`timescale 1ns / 1ps

module mlfq_dpath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  mlfq_pkg::ctrl_cmd_t         cmd,
    output mlfq_pkg::ctrl_sts_t         sts,
    input  logic [mlfq_pkg::SLOT_W-1:0] idle_slot,
    mlfq_in_if.sink                     req,
    mlfq_out_if.source                  rsp
);
    import mlfq_pkg::*;

    localparam int DEN_W = RCPU_W + 2;
    localparam int REM_W = RCPU_W + 3;
    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    localparam logic signed [PROD_W-1:0] RCPU_HI =
        {{(PROD_W-RCPU_W+1){1'b0}}, {(RCPU_W-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] RCPU_LO =
        {{(PROD_W-RCPU_W+1){1'b1}}, {(RCPU_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] MAXFP   = PROD_W'(PRIORITY_MAX * FP_ONE);
    localparam logic signed [PROD_W-1:0] ONE_W   = PROD_W'(FP_ONE);
    localparam logic signed [PROD_W-1:0] HALF_W  = PROD_W'(FP_HALF);
    localparam logic signed [PROD_W-1:0] LA_MAX  = PROD_W'(LA_OUT_MAX);
    localparam logic signed [PROD_W-1:0] RC_MAX  = PROD_W'(RC_OUT_MAX);
    localparam logic signed [PROD_W-1:0] RC_MIN  = PROD_W'(RC_OUT_MIN);

    function automatic logic signed [RCPU_W-1:0] sat_rcpu(input logic signed [PROD_W-1:0] v);
        if (v > RCPU_HI)
        begin
            return RCPU_HI[RCPU_W-1:0];
        end
        if (v < RCPU_LO)
        begin
            return RCPU_LO[RCPU_W-1:0];
        end
        return v[RCPU_W-1:0];
    endfunction

    // Captured event
    logic [OP_W-1:0]          op_reg,     op_next;
    logic [SLOT_W-1:0]        slot_reg,   slot_next;
    logic [SLOT_W-1:0]        parent_reg, parent_next;
    logic signed [NICE_W-1:0] nice_in_reg, nice_in_next;
    logic [READY_W-1:0]       rdy_reg,    rdy_next;

    // Architectural state outside the RAM
    logic signed [RCPU_W-1:0] load_reg, load_next;
    logic [THREAD_SLOTS-1:0]  live_reg, live_next;
    logic [THREAD_SLOTS-1:0]  ent_valid_reg, ent_valid_next;
    logic                     rd_valid_reg;

    // Work registers
    logic [SLOT_W-1:0]        idx_reg, idx_next;
    logic signed [NICE_W-1:0] wnice_reg, wnice_next;
    logic signed [RCPU_W-1:0] wrcpu_reg, wrcpu_next;
    logic [PRI_W-1:0]         wprio_reg, wprio_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [FRACTION_BITS-1:0] coeff_reg, coeff_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [CNT_W-1:0]         dcnt_reg, dcnt_next;
    logic [LA_OUT_W-1:0]      la_res_reg, la_res_next;
    logic signed [RC_OUT_W-1:0] rc_res_reg, rc_res_next;

    // Result register
    logic                       out_valid_reg, out_valid_next;
    logic [LA_OUT_W-1:0]        out_la_reg, out_la_next;
    logic signed [RC_OUT_W-1:0] out_rc_reg, out_rc_next;
    logic [PRIO_OUT_W-1:0]      out_pr_reg, out_pr_next;

    // Combinational helpers
    logic                       in_xfer;
    logic [SLOT_W-1:0]          work_slot;
    logic [SLOT_W-1:0]          raddr;
    logic [RAM_W-1:0]           rdata;
    logic signed [RCPU_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic [READY_W:0]           ready_eff;
    logic signed [PROD_W-1:0]   tmp_a;
    logic signed [PROD_W-1:0]   tmp_b;
    logic [REM_W-1:0]           rem_sh;

    assign in_xfer   = cmd.in_ready && req.valid;
    assign work_slot = (op_reg == OP_RECALC) ? idx_reg : slot_reg;
    assign raddr     = cmd.rd_parent ? parent_reg : (cmd.rd_report ? slot_reg : work_slot);

    mlfq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (THREAD_SLOTS)
    ) u_tbl (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (work_slot),
        .wdata ({wnice_reg, wrcpu_reg, wprio_reg}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Shared multiplier operand select
    always_comb
    begin
        if (cmd.mul_load59 || cmd.mul_la)
        begin
            mul_a = load_reg;
        end
        else
        begin
            mul_a = wrcpu_reg;
        end
        if (cmd.mul_load59)
        begin
            mul_b = MUL_B_W'(C59);
        end
        else if (cmd.mul_coeff)
        begin
            mul_b = MUL_B_W'(coeff_reg);
        end
        else
        begin
            mul_b = MUL_B_W'(PCT_SCALE);
        end
    end

    always_comb
    begin
        op_next        = op_reg;
        slot_next      = slot_reg;
        parent_next    = parent_reg;
        nice_in_next   = nice_in_reg;
        rdy_next       = rdy_reg;
        load_next      = load_reg;
        live_next      = live_reg;
        ent_valid_next = ent_valid_reg;
        idx_next       = idx_reg;
        wnice_next     = wnice_reg;
        wrcpu_next     = wrcpu_reg;
        wprio_next     = wprio_reg;
        prod_next      = prod_reg;
        coeff_next     = coeff_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        la_res_next    = la_res_reg;
        rc_res_next    = rc_res_reg;
        out_la_next    = out_la_reg;
        out_rc_next    = out_rc_reg;
        out_pr_next    = out_pr_reg;
        out_valid_next = out_valid_reg;
        ready_eff      = '0;
        tmp_a          = '0;
        tmp_b          = '0;
        rem_sh         = '0;

        if (in_xfer)
        begin
            op_next     = req.opcode;
            slot_next   = req.thread_slot[SLOT_W-1:0];
            parent_next = req.parent_slot[SLOT_W-1:0];
            rdy_next    = req.ready_list_length;
            if (req.nice_value > NICE_IN_W'(NICE_LIMIT))
            begin
                nice_in_next = NICE_W'(NICE_LIMIT);
            end
            else if (req.nice_value < -NICE_IN_W'(NICE_LIMIT))
            begin
                nice_in_next = -NICE_W'(NICE_LIMIT);
            end
            else
            begin
                nice_in_next = req.nice_value[NICE_W-1:0];
            end
        end

        if (cmd.mul_load59 || cmd.mul_coeff || cmd.mul_la || cmd.mul_rc)
        begin
            prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        end

        // load = 59/60 * load + 1/60 * ready; load is never negative
        if (cmd.load_upd)
        begin
            ready_eff = {1'b0, rdy_reg} + ((slot_reg == idle_slot) ? 1'b0 : 1'b1);
            tmp_a     = (prod_reg >>> FRACTION_BITS)
                        + PROD_W'(C1) * PROD_W'($signed({1'b0, ready_eff}));
            if (tmp_a < 0)
            begin
                tmp_a = '0;
            end
            load_next = sat_rcpu(tmp_a);
        end

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // coeff = 2L * one / (2L + one), one quotient bit per cycle
        if (cmd.div_init)
        begin
            rem_next   = REM_W'({load_reg, 1'b0});
            den_next   = DEN_W'({load_reg, 1'b0}) + DEN_W'(FP_ONE);
            dcnt_next  = CNT_W'(FRACTION_BITS);
            coeff_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_sh = {rem_reg[REM_W-2:0], 1'b0};
            if (rem_sh >= REM_W'(den_reg))
            begin
                rem_next   = rem_sh - REM_W'(den_reg);
                coeff_next = {coeff_reg[FRACTION_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next   = rem_sh;
                coeff_next = {coeff_reg[FRACTION_BITS-2:0], 1'b0};
            end
            dcnt_next = dcnt_reg - 1'b1;
        end

        // Entries never written read as their reset values
        if (cmd.latch)
        begin
            if (rd_valid_reg)
            begin
                wnice_next = rdata[RAM_W-1 -: NICE_W];
                wrcpu_next = rdata[PRI_W +: RCPU_W];
                wprio_next = rdata[PRI_W-1:0];
            end
            else
            begin
                wnice_next = '0;
                wrcpu_next = '0;
                wprio_next = PRI_W'(PRIORITY_MAX);
            end
            if (cmd.use_nice_in)
            begin
                wnice_next = nice_in_reg;
            end
        end

        if (cmd.tick_add)
        begin
            wrcpu_next = sat_rcpu(PROD_W'(wrcpu_reg) + ONE_W);
        end

        // rcpu = coeff * rcpu / one (toward zero) + nice * one
        if (cmd.rcpu_upd)
        begin
            tmp_a = prod_reg + ((prod_reg < 0) ? (ONE_W - 1) : PROD_W'(0));
            tmp_b = (tmp_a >>> FRACTION_BITS) + (PROD_W'(wnice_reg) <<< FRACTION_BITS);
            wrcpu_next = sat_rcpu(tmp_b);
        end

        // prio = max - rcpu/4 - 2*nice, clamped, then integer part
        if (cmd.prio_upd)
        begin
            tmp_a = PROD_W'(wrcpu_reg) + ((wrcpu_reg < 0) ? PROD_W'(3) : PROD_W'(0));
            tmp_b = MAXFP - (tmp_a >>> 2) - (PROD_W'(wnice_reg) <<< (FRACTION_BITS + 1));
            if (tmp_b > MAXFP)
            begin
                tmp_b = MAXFP;
            end
            if (tmp_b < 0)
            begin
                tmp_b = '0;
            end
            wprio_next = tmp_b[FRACTION_BITS +: PRI_W];
        end

        if (cmd.wr)
        begin
            ent_valid_next[work_slot] = 1'b1;
        end
        if (cmd.live_set)
        begin
            live_next[work_slot] = 1'b1;
        end
        if (cmd.live_clr)
        begin
            live_next[slot_reg] = 1'b0;
        end

        if (cmd.la_out)
        begin
            tmp_a = (prod_reg + HALF_W) >>> FRACTION_BITS;
            if (tmp_a > LA_MAX)
            begin
                tmp_a = LA_MAX;
            end
            if (tmp_a < 0)
            begin
                tmp_a = '0;
            end
            la_res_next = tmp_a[LA_OUT_W-1:0];
        end

        // round half away from zero
        if (cmd.rc_out)
        begin
            if (prod_reg >= 0)
            begin
                tmp_a = (prod_reg + HALF_W) >>> FRACTION_BITS;
            end
            else
            begin
                tmp_a = -((HALF_W - prod_reg) >>> FRACTION_BITS);
            end
            if (tmp_a > RC_MAX)
            begin
                tmp_a = RC_MAX;
            end
            if (tmp_a < RC_MIN)
            begin
                tmp_a = RC_MIN;
            end
            rc_res_next = tmp_a[RC_OUT_W-1:0];
        end

        if (cmd.out_load)
        begin
            out_la_next    = la_res_reg;
            out_rc_next    = rc_res_reg;
            out_pr_next    = PRIO_OUT_W'(wprio_reg);
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_reg      <= '0;
            live_reg      <= THREAD_SLOTS'(1);
            ent_valid_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            load_reg      <= load_next;
            live_reg      <= live_next;
            ent_valid_reg <= ent_valid_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        parent_reg   <= parent_next;
        nice_in_reg  <= nice_in_next;
        rdy_reg      <= rdy_next;
        rd_valid_reg <= ent_valid_reg[raddr];
        wnice_reg    <= wnice_next;
        wrcpu_reg    <= wrcpu_next;
        wprio_reg    <= wprio_next;
        prod_reg     <= prod_next;
        coeff_reg    <= coeff_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        la_res_reg   <= la_res_next;
        rc_res_reg   <= rc_res_next;
        out_la_reg   <= out_la_next;
        out_rc_reg   <= out_rc_next;
        out_pr_reg   <= out_pr_next;
    end

    assign req.ready           = cmd.in_ready;
    assign rsp.valid           = out_valid_reg;
    assign rsp.load_avg_x100   = out_la_reg;
    assign rsp.recent_cpu_x100 = out_rc_reg;
    assign rsp.thread_priority = out_pr_reg;

    always_comb
    begin
        sts.op       = op_reg;
        sts.in_valid = req.valid;
        sts.is_idle  = (slot_reg == idle_slot);
        sts.walk_ok  = live_reg[idx_reg] && (idx_reg != idle_slot);
        sts.idx_last = (idx_reg == SLOT_W'(THREAD_SLOTS - 1));
        sts.div_done = (dcnt_reg == '0);
        sts.out_free = !out_valid_reg || rsp.ready;
    end
endmodule

// ----- rtl/mlfq_priority_update_engine.sv -----
// MLFQ priority update engine top level: idle-slot register, controller and datapath.
// Recalc updates each live non-idle slot in a 64-slot walk, using one RAM read port
// and one multiplier.
// One event in flight; a held result stalls the engine.
// Reset: async active low; load 0, slot 0 live, all entries read as reset values.
// Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if, mlfq_ctrl, mlfq_dpath.
`timescale 1ns / 1ps

module mlfq_priority_update_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    mlfq_in_if.sink                     req,
    mlfq_out_if.source                  rsp,
    input  logic                        cfg_wr_en,
    input  logic [mlfq_pkg::SLOT_FIELD_W-1:0] cfg_wr_data
);
    import mlfq_pkg::*;

    logic [SLOT_W-1:0] idle_slot_reg;
    logic [SLOT_W-1:0] idle_slot_next;
    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;

    assign idle_slot_next = cfg_wr_en ? cfg_wr_data[SLOT_W-1:0] : idle_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_slot_reg <= SLOT_W'(1);
        end
        else
        begin
            idle_slot_reg <= idle_slot_next;
        end
    end

    mlfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    mlfq_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .idle_slot (idle_slot_reg),
        .req       (req),
        .rsp       (rsp)
    );

    // one event at a time: ready drops right after a transfer
    a_single_event: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("event accepted while another is in flight");

    a_la_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.load_avg_x100 <= LA_OUT_W'(LA_OUT_MAX)))
        else $error("load average report out of range");

    a_rc_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.recent_cpu_x100 <= RC_OUT_W'(RC_OUT_MAX)
                       && rsp.recent_cpu_x100 >= RC_OUT_W'(RC_OUT_MIN)))
        else $error("recent cpu report out of range");

    // the result register is only loaded while the controller holds off input
    a_load_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !req.ready)
        else $error("result loaded while accepting an event");
endmodule

// ----- bench/tb_mlfq_priority_update_engine.sv -----
// Testbench for the MLFQ priority update engine: directed and random events,
// predicted results checked in order. Depends on mlfq_pkg, mlfq_in_if, mlfq_out_if.
`timescale 1ns / 1ps

class mlfq_scoreboard;
    typedef struct packed {
        logic [mlfq_pkg::LA_OUT_W-1:0]        la;
        logic signed [mlfq_pkg::RC_OUT_W-1:0] rc;
        logic [mlfq_pkg::PRIO_OUT_W-1:0]      prio;
    } report_t;

    bit [5:0]           idle;
    logic signed [7:0]  nice_tab [64];
    logic signed [31:0] rcpu_tab [64];
    logic [5:0]         prio_tab [64];
    bit                 live_tab [64];
    logic signed [31:0] load;
    report_t            pending_reports [$];
    int                 errors;
    int                 checked;

    function new();
        idle = 1;
        load = 0;
        errors = 0;
        checked = 0;
        for (int i = 0; i < 64; i++)
        begin
            nice_tab[i] = 0;
            rcpu_tab[i] = 0;
            prio_tab[i] = 6'(mlfq_pkg::PRIORITY_MAX);
            live_tab[i] = (i == 0);
        end
    endfunction

    function logic signed [31:0] sat32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function void refresh_prio(int s);
        longint maxfp;
        longint p;
        maxfp = longint'(mlfq_pkg::PRIORITY_MAX) * mlfq_pkg::FP_ONE;
        p = maxfp - longint'(rcpu_tab[s]) / 4 - longint'(nice_tab[s]) * 2 * mlfq_pkg::FP_ONE;
        if (p > maxfp)
            p = maxfp;
        if (p < 0)
            p = 0;
        prio_tab[s] = 6'(p / mlfq_pkg::FP_ONE);
    endfunction

    function void decay_rcpu(int s);
        longint two_la;
        longint coeff;
        two_la = longint'(load) * 2;
        coeff = two_la * mlfq_pkg::FP_ONE / (two_la + mlfq_pkg::FP_ONE);
        rcpu_tab[s] = sat32(coeff * longint'(rcpu_tab[s]) / mlfq_pkg::FP_ONE
                            + longint'(nice_tab[s]) * mlfq_pkg::FP_ONE);
    endfunction

    // Note an accepted event: update the table copy and queue the report.
    function void note_event(logic [2:0] op, logic [5:0] s, logic [5:0] ps,
                             logic signed [7:0] nv, logic [6:0] rdy);
        bit      at_idle;
        longint  v;
        longint  n;
        report_t r;
        at_idle = (s == idle);
        case (op)
            mlfq_pkg::OP_TICK:
                if (!at_idle)
                    rcpu_tab[s] = sat32(longint'(rcpu_tab[s]) + mlfq_pkg::FP_ONE);
            mlfq_pkg::OP_RECALC:
            begin
                v = longint'(mlfq_pkg::C59) * load / mlfq_pkg::FP_ONE
                    + longint'(mlfq_pkg::C1) * ((longint'(rdy) + (at_idle ? 0 : 1))
                      * mlfq_pkg::FP_ONE) / mlfq_pkg::FP_ONE;
                if (v < 0)
                    v = 0;
                load = sat32(v);
                for (int i = 0; i < 64; i++)
                    if (live_tab[i] && i != idle)
                    begin
                        decay_rcpu(i);
                        refresh_prio(i);
                    end
            end
            mlfq_pkg::OP_SET_NICE:
                if (!at_idle)
                begin
                    n = nv;
                    if (n > 20)
                        n = 20;
                    if (n < -20)
                        n = -20;
                    nice_tab[s] = 8'(n);
                    decay_rcpu(s);
                    refresh_prio(s);
                end
            mlfq_pkg::OP_CREATE:
                if (!at_idle)
                begin
                    nice_tab[s] = nice_tab[ps];
                    rcpu_tab[s] = rcpu_tab[ps];
                    live_tab[s] = 1;
                    refresh_prio(s);
                end
            mlfq_pkg::OP_EXIT:
                if (!at_idle)
                    live_tab[s] = 0;
            default: ;
        endcase
        v = (longint'(load) * 100 + mlfq_pkg::FP_HALF) / mlfq_pkg::FP_ONE;
        if (v > mlfq_pkg::LA_OUT_MAX)
            v = mlfq_pkg::LA_OUT_MAX;
        if (v < 0)
            v = 0;
        r.la = 20'(v);
        v = longint'(rcpu_tab[s]) * 100;
        if (v >= 0)
            v = (v + mlfq_pkg::FP_HALF) / mlfq_pkg::FP_ONE;
        else
            v = (v - mlfq_pkg::FP_HALF) / mlfq_pkg::FP_ONE;
        if (v > mlfq_pkg::RC_OUT_MAX)
            v = mlfq_pkg::RC_OUT_MAX;
        if (v < mlfq_pkg::RC_OUT_MIN)
            v = mlfq_pkg::RC_OUT_MIN;
        r.rc = 25'(v);
        r.prio = prio_tab[s];
        pending_reports.push_back(r);
    endfunction

    function void check_report(logic [19:0] la, logic signed [24:0] rc, logic [5:0] prio);
        report_t e;
        checked++;
        if (pending_reports.size() == 0)
        begin
            $error("unexpected result transfer");
            errors++;
            return;
        end
        e = pending_reports.pop_front();
        if (la !== e.la)
        begin
            $error("load_avg_x100 expected %0d actual %0d", e.la, la);
            errors++;
        end
        if (rc !== e.rc)
        begin
            $error("recent_cpu_x100 expected %0d actual %0d", e.rc, rc);
            errors++;
        end
        if (prio !== e.prio)
        begin
            $error("thread_priority expected %0d actual %0d", e.prio, prio);
            errors++;
        end
    endfunction
endclass

module tb_mlfq_priority_update_engine;
    import mlfq_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [5:0]  cfg_wr_data;
    int          long_hold;
    int          sent;
    int          recalcs;

    mlfq_in_if  req ();
    mlfq_out_if rsp ();
    mlfq_scoreboard board;

    mlfq_priority_update_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req.sink),
        .rsp         (rsp.source),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 0;
        #5;
        clk = 1;
        #5;
    end

    function int short_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // valid drops at the transfer edge; the next event is offered once the requested gap
    // has passed, possibly before the engine can take it again
    task automatic send_event(logic [2:0] op, logic [5:0] s, logic [5:0] ps,
                              logic signed [7:0] nv, logic [6:0] rdy, int gap);
        repeat (gap + 1)
            @(posedge clk);
        req.valid             <= 1;
        req.opcode            <= op;
        req.thread_slot       <= s;
        req.parent_slot       <= ps;
        req.nice_value        <= nv;
        req.ready_list_length <= rdy;
        do
            @(posedge clk);
        while (!req.ready);
        board.note_event(op, s, ps, nv, rdy);
        sent++;
        if (op == OP_RECALC)
            recalcs++;
        req.valid <= 0;
    endtask

    task automatic drain();
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (600)
            @(posedge clk);
    endtask

    task automatic write_idle(logic [5:0] v);
        drain();
        cfg_wr_en   <= 1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 0;
        board.idle = v;
    endtask

    // Mostly a small live set with creates, ticks and recalcs; some noise.
    task automatic random_event(int gap);
        logic [2:0] op;
        logic [5:0] s;
        int         k;
        k = $urandom_range(0, 99);
        if (k < 35)
            op = OP_TICK;
        else if (k < 50)
            op = OP_RECALC;
        else if (k < 65)
            op = OP_SET_NICE;
        else if (k < 80)
            op = OP_CREATE;
        else if (k < 88)
            op = OP_EXIT;
        else
            op = 3'($urandom_range(5, 7));
        s = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        send_event(op, s, ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7)),
                   ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 50) - 25),
                   7'($urandom_range(0, 64)), gap);
    endtask

    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            board.check_report(rsp.load_avg_x100, rsp.recent_cpu_x100, rsp.thread_priority);
        if (long_hold > 0)
        begin
            long_hold <= long_hold - 1;
            rsp.ready <= 0;
        end
        else
            rsp.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    initial
    begin
        #300ms;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        board = new();
        rst_n = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        long_hold = 0;
        sent = 0;
        recalcs = 0;
        req.valid = 0;
        req.opcode = OP_QUERY;
        req.thread_slot = 0;
        req.parent_slot = 0;
        req.nice_value = 0;
        req.ready_list_length = 0;
        rsp.ready = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: every opcode, field extremes, idle and non-live targets.
        send_event(OP_QUERY, 0, 0, 0, 0, 0);
        send_event(OP_TICK, 0, 0, 0, 0, 0);
        send_event(OP_TICK, 1, 0, 0, 0, 1);
        send_event(OP_SET_NICE, 1, 0, 127, 0, 0);
        send_event(OP_SET_NICE, 0, 0, -128, 0, 0);
        send_event(OP_SET_NICE, 63, 0, 127, 0, 0);
        send_event(OP_CREATE, 2, 0, 0, 0, 0);
        send_event(OP_CREATE, 63, 63, 0, 0, 0);
        send_event(OP_CREATE, 1, 0, 0, 0, 0);
        send_event(OP_TICK, 40, 0, 0, 0, 0);
        send_event(OP_CREATE, 41, 40, 0, 0, 0);
        send_event(OP_RECALC, 0, 0, 0, 64, 0);
        send_event(OP_RECALC, 1, 0, 0, 0, 0);
        send_event(OP_RECALC, 2, 63, -1, 127, 0);
        send_event(OP_EXIT, 2, 0, 0, 0, 0);
        send_event(OP_EXIT, 1, 0, 0, 0, 0);
        send_event(3'd6, 63, 63, 0, 0, 0);
        send_event(3'd7, 0, 0, 0, 0, 0);
        send_event(OP_SET_NICE, 2, 0, -21, 0, 0);
        send_event(OP_QUERY, 2, 0, 0, 0, 0);
        write_idle(0);
        send_event(OP_TICK, 0, 0, 0, 0, 0);
        send_event(OP_RECALC, 63, 0, 0, 64, 0);
        write_idle(63);
        send_event(OP_EXIT, 63, 0, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++)
        begin
            if (phase == 1)
            begin
                long_hold = 400;
                repeat (20)
                    random_event(0);
            end
            for (int n = 0; n < 360; n++)
                random_event(short_gap());
            if (phase == 2)
                drain();   // sender waits for every result
            write_idle(phase == 3 ? 6'd1 : 6'($urandom));
        end
        // long run of ticks spread over slots 2 to 4
        for (int n = 0; n < 60; n++)
            send_event(OP_TICK, 6'($urandom_range(2, 4)), 0, 0, 0, 0);
        drain();
        $display("Covered %0d events (%0d recalcs), %0d results checked.",
                 sent, recalcs, board.checked);
        if (board.errors == 0 && board.pending_reports.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/mlfq_pkg.sv
rtl/mlfq_in_if.sv
rtl/mlfq_out_if.sv
rtl/mlfq_ram.sv
rtl/mlfq_ctrl.sv
rtl/mlfq_dpath.sv
rtl/mlfq_priority_update_engine.sv
bench/tb_mlfq_priority_update_engine.sv
